>>> sv/sttk_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the source text tokenizer.
// No dependencies; all other source files but sttk_if refer to this package by scoped names.
package sttk_pkg;

   localparam int MaxTokenChars = 255;
   localparam int CountW        = $clog2(MaxTokenChars + 1);
   localparam int LenMax        = 255;
   localparam int KwCount       = 7;
   localparam int RspDepth      = 4;
   localparam int RspPtrW       = $clog2(RspDepth);
   localparam int RspCntW       = $clog2(RspDepth + 1);

   // scan modes
   localparam logic [2:0] ModeIdle    = 3'd0;
   localparam logic [2:0] ModeSlash   = 3'd1;
   localparam logic [2:0] ModeComment = 3'd2;
   localparam logic [2:0] ModeIdent   = 3'd3;
   localparam logic [2:0] ModeNumber  = 3'd4;
   localparam logic [2:0] ModeString  = 3'd5;

   // token classes
   localparam logic [2:0] ClsEof     = 3'd0;
   localparam logic [2:0] ClsKeyword = 3'd1;
   localparam logic [2:0] ClsIdent   = 3'd2;
   localparam logic [2:0] ClsNumber  = 3'd3;
   localparam logic [2:0] ClsString  = 3'd4;
   localparam logic [2:0] ClsSymbol  = 3'd5;

   localparam logic [2:0] KwNone = 3'd0;

   localparam logic [7:0] ChEnd        = 8'h00;
   localparam logic [7:0] ChNewline    = 8'h0A;
   localparam logic [7:0] ChQuote      = 8'h22;
   localparam logic [7:0] ChSlash      = 8'h2F;
   localparam logic [7:0] ChUnderscore = 8'h5F;

   typedef struct packed {
      logic       has_char;
      logic [7:0] value_char;
      logic       token_end;
      logic [2:0] token_class;
      logic [2:0] keyword_id;
      logic [7:0] value_length;
      logic       truncated;
      logic       last_of_run;
   } rsp_type;

   // up to two results produced by one byte, in delivery order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // character pos of keyword k (k = keyword_id - 1), first character at pos 0
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
      logic [47:0] text;
      int          idx;
      unique case (k)
         3'd0:    text = {"fn", 32'h0};
         3'd1:    text = {"let", 24'h0};
         3'd2:    text = {"int", 24'h0};
         3'd3:    text = {"str", 24'h0};
         3'd4:    text = "return";
         3'd5:    text = {"if", 32'h0};
         3'd6:    text = {"while", 8'h0};
         default: text = '0;
      endcase
      if (pos > 3'd5) return 8'h00;
      idx = 5 - int'(pos);
      return text[idx*8 +: 8];
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] k);
      unique case (k)
         3'd0:    return 3'd2;
         3'd1:    return 3'd3;
         3'd2:    return 3'd3;
         3'd3:    return 3'd3;
         3'd4:    return 3'd6;
         3'd5:    return 3'd2;
         3'd6:    return 3'd5;
         default: return 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] sat_len(input logic [CountW-1:0] n);
      if (int'(n) > LenMax) return 8'(LenMax);
      return 8'(n);
   endfunction

   function automatic rsp_type mk_char(input logic [7:0] c);
      rsp_type r;
      r            = '0;
      r.has_char   = 1'b1;
      r.value_char = c;
      return r;
   endfunction

   function automatic rsp_type mk_end(input logic [2:0] cls, input logic [2:0] kw,
                                      input logic [7:0] len, input logic trunc);
      rsp_type r;
      r              = '0;
      r.token_end    = 1'b1;
      r.token_class  = cls;
      r.keyword_id   = kw;
      r.value_length = len;
      r.truncated    = trunc;
      return r;
   endfunction

   function automatic rsp_type mk_symbol(input logic [7:0] c);
      rsp_type r;
      r              = '0;
      r.has_char     = 1'b1;
      r.value_char   = c;
      r.token_end    = 1'b1;
      r.token_class  = ClsSymbol;
      r.value_length = 8'd1;
      return r;
   endfunction

endpackage

>>> sv/sttk_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tokenizer's byte input and result output.
// Depends on nothing; the result fields match sttk_pkg::rsp_type.
interface sttk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface sttk_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_char;
   logic [7:0] value_char;
   logic       token_end;
   logic [2:0] token_class;
   logic [2:0] keyword_id;
   logic [7:0] value_length;
   logic       truncated;
   logic       last_of_run;

   modport source (output valid, output has_char, output value_char, output token_end,
                   output token_class, output keyword_id, output value_length,
                   output truncated, output last_of_run, input ready);
   modport sink   (input valid, input has_char, input value_char, input token_end,
                   input token_class, input keyword_id, input value_length,
                   input truncated, input last_of_run, output ready);
endinterface

>>> sv/sttk_scan.sv
`timescale 1ns / 1ps
// Input byte register and scanner: mode update, keyword match, result generation.
// Depends on sttk_pkg and sttk_req_if.
module sttk_scan (
   input  logic                   clock,
   input  logic                   reset,
   sttk_req_if.sink               req_chan,
   input  logic                   room,
   output sttk_pkg::push_type     push
);

   logic                          pend_ff, pend_in;
   logic [7:0]                    ch_ff, ch_in;
   logic [2:0]                    mode_ff, mode_in;
   logic [sttk_pkg::KwCount-1:0]  cand_ff, cand_in;
   logic [sttk_pkg::CountW-1:0]   count_ff, count_in;
   logic                          ovf_ff, ovf_in;

   logic                          process;
   logic                          accept;
   logic [7:0]                    c;

   // handle-as-idle path
   logic [2:0]                    idle_mode;
   logic [sttk_pkg::KwCount-1:0]  idle_cand;
   logic [sttk_pkg::CountW-1:0]   idle_count;
   logic                          idle_ovf;
   logic                          idle_v;
   sttk_pkg::rsp_type             idle_r;

   // append path
   logic                          app_full;
   logic [sttk_pkg::KwCount-1:0]  app_cand;

   // token close path
   logic [2:0]                    fin_kw;
   sttk_pkg::rsp_type             fin_ident_r;

   logic                          pre_v, sec_v, use_idle;
   sttk_pkg::rsp_type             pre_r, sec_r;

   assign c       = ch_ff;
   assign process = pend_ff && room;
   assign req_chan.ready = !pend_ff || room;
   assign accept  = req_chan.valid && req_chan.ready;

   always_comb begin
      pend_in = pend_ff;
      ch_in   = ch_ff;
      if (accept) begin
         pend_in = 1'b1;
         ch_in   = req_chan.ch;
      end else if (process) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      idle_mode  = sttk_pkg::ModeIdle;
      idle_cand  = cand_ff;
      idle_count = count_ff;
      idle_ovf   = ovf_ff;
      idle_v     = 1'b0;
      idle_r     = '0;
      if (c == sttk_pkg::ChEnd) begin
         idle_v = 1'b1;
         idle_r = sttk_pkg::mk_end(sttk_pkg::ClsEof, sttk_pkg::KwNone, 8'd0, 1'b0);
      end else if (sttk_pkg::is_space(c)) begin
         idle_mode = sttk_pkg::ModeIdle;
      end else if (c == sttk_pkg::ChSlash) begin
         idle_mode = sttk_pkg::ModeSlash;
      end else if (sttk_pkg::is_alpha(c) || c == sttk_pkg::ChUnderscore) begin
         idle_mode  = sttk_pkg::ModeIdent;
         idle_count = sttk_pkg::CountW'(1);
         idle_ovf   = 1'b0;
         for (int k = 0; k < sttk_pkg::KwCount; k++) begin
            idle_cand[k] = sttk_pkg::kw_char(3'(k), 3'd0) == c;
         end
         idle_v = 1'b1;
         idle_r = sttk_pkg::mk_char(c);
      end else if (sttk_pkg::is_digit(c)) begin
         idle_mode  = sttk_pkg::ModeNumber;
         idle_count = sttk_pkg::CountW'(1);
         idle_ovf   = 1'b0;
         idle_cand  = '0;
         idle_v     = 1'b1;
         idle_r     = sttk_pkg::mk_char(c);
      end else if (c == sttk_pkg::ChQuote) begin
         idle_mode  = sttk_pkg::ModeString;
         idle_count = '0;
         idle_ovf   = 1'b0;
         idle_cand  = '0;
      end else begin
         idle_v = 1'b1;
         idle_r = sttk_pkg::mk_symbol(c);
      end
   end

   always_comb begin
      app_full = count_ff >= sttk_pkg::CountW'(sttk_pkg::MaxTokenChars);
      for (int k = 0; k < sttk_pkg::KwCount; k++) begin
         app_cand[k] = cand_ff[k]
                       && (count_ff < sttk_pkg::CountW'(sttk_pkg::kw_len(3'(k))))
                       && (sttk_pkg::kw_char(3'(k), count_ff[2:0]) == c);
      end
   end

   always_comb begin
      fin_kw = sttk_pkg::KwNone;
      for (int k = 0; k < sttk_pkg::KwCount; k++) begin
         if (cand_ff[k] && sttk_pkg::CountW'(sttk_pkg::kw_len(3'(k))) == count_ff) begin
            fin_kw = 3'(k + 1);
         end
      end
      if (!ovf_ff && fin_kw != sttk_pkg::KwNone) begin
         fin_ident_r = sttk_pkg::mk_end(sttk_pkg::ClsKeyword, fin_kw,
                                        sttk_pkg::sat_len(count_ff), 1'b0);
      end else begin
         fin_ident_r = sttk_pkg::mk_end(sttk_pkg::ClsIdent, sttk_pkg::KwNone,
                                        sttk_pkg::sat_len(count_ff), ovf_ff);
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      cand_in  = cand_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pre_v    = 1'b0;
      pre_r    = '0;
      sec_v    = 1'b0;
      sec_r    = '0;
      use_idle = 1'b0;
      unique case (mode_ff)
         sttk_pkg::ModeSlash: begin
            if (c == sttk_pkg::ChSlash) begin
               mode_in = sttk_pkg::ModeComment;
            end else begin
               pre_v    = 1'b1;
               pre_r    = sttk_pkg::mk_symbol(sttk_pkg::ChSlash);
               use_idle = 1'b1;
            end
         end
         sttk_pkg::ModeComment: begin
            if (c == sttk_pkg::ChEnd) begin
               pre_v   = 1'b1;
               pre_r   = sttk_pkg::mk_end(sttk_pkg::ClsEof, sttk_pkg::KwNone, 8'd0, 1'b0);
               mode_in = sttk_pkg::ModeIdle;
            end else if (c == sttk_pkg::ChNewline) begin
               mode_in = sttk_pkg::ModeIdle;
            end
         end
         sttk_pkg::ModeIdent: begin
            if (sttk_pkg::is_alpha(c) || sttk_pkg::is_digit(c)
                || c == sttk_pkg::ChUnderscore) begin
               if (app_full) begin
                  ovf_in = 1'b1;
               end else begin
                  pre_v    = 1'b1;
                  pre_r    = sttk_pkg::mk_char(c);
                  count_in = count_ff + sttk_pkg::CountW'(1);
                  cand_in  = app_cand;
               end
            end else begin
               pre_v    = 1'b1;
               pre_r    = fin_ident_r;
               use_idle = 1'b1;
            end
         end
         sttk_pkg::ModeNumber: begin
            if (sttk_pkg::is_digit(c)) begin
               if (app_full) begin
                  ovf_in = 1'b1;
               end else begin
                  pre_v    = 1'b1;
                  pre_r    = sttk_pkg::mk_char(c);
                  count_in = count_ff + sttk_pkg::CountW'(1);
               end
            end else begin
               pre_v    = 1'b1;
               pre_r    = sttk_pkg::mk_end(sttk_pkg::ClsNumber, sttk_pkg::KwNone,
                                           sttk_pkg::sat_len(count_ff), ovf_ff);
               use_idle = 1'b1;
            end
         end
         sttk_pkg::ModeString: begin
            if (c == sttk_pkg::ChQuote || c == sttk_pkg::ChEnd) begin
               pre_v   = 1'b1;
               pre_r   = sttk_pkg::mk_end(sttk_pkg::ClsString, sttk_pkg::KwNone,
                                          sttk_pkg::sat_len(count_ff), ovf_ff);
               mode_in = sttk_pkg::ModeIdle;
               // unterminated string: end of text closes it, then eof follows
               if (c == sttk_pkg::ChEnd) begin
                  sec_v = 1'b1;
                  sec_r = sttk_pkg::mk_end(sttk_pkg::ClsEof, sttk_pkg::KwNone, 8'd0, 1'b0);
               end
            end else if (app_full) begin
               ovf_in = 1'b1;
            end else begin
               pre_v    = 1'b1;
               pre_r    = sttk_pkg::mk_char(c);
               count_in = count_ff + sttk_pkg::CountW'(1);
            end
         end
         default: begin
            use_idle = 1'b1;
         end
      endcase
      if (use_idle) begin
         mode_in  = idle_mode;
         cand_in  = idle_cand;
         count_in = idle_count;
         ovf_in   = idle_ovf;
         sec_v    = idle_v;
         sec_r    = idle_r;
      end
   end

   // pack results to the front and flag the last one
   always_comb begin
      push = '0;
      if (process) begin
         if (pre_v) begin
            push.first  = pre_r;
            push.second = sec_r;
            push.count  = sec_v ? 2'd2 : 2'd1;
         end else begin
            push.first  = sec_r;
            push.count  = sec_v ? 2'd1 : 2'd0;
         end
         if (push.count == 2'd2) begin
            push.second.last_of_run = 1'b1;
         end else begin
            push.first.last_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         mode_ff  <= sttk_pkg::ModeIdle;
         cand_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (process) begin
            mode_ff  <= mode_in;
            cand_ff  <= cand_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
   end

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sttk_pkg::CountW'(sttk_pkg::MaxTokenChars))
      else $error("token character count beyond limit");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.second.last_of_run && !push.first.last_of_run)
      else $error("last_of_run on wrong result of a pair");

   a_comment_silent: assert property (@(posedge clock) disable iff (reset)
      process && mode_ff == sttk_pkg::ModeComment && c != sttk_pkg::ChEnd
      |-> push.count == 2'd0)
      else $error("result produced inside a line comment");

   a_no_work_when_full: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !room |=> pend_ff && $stable(ch_ff))
      else $error("held byte lost while queue was full");

endmodule

>>> sv/sttk_rsp_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle and hands them out one per transfer.
// Depends on sttk_pkg and sttk_rsp_if.
module sttk_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  sttk_pkg::push_type  push,
   output logic                room,
   sttk_rsp_if.source          rsp_chan
);

   sttk_pkg::rsp_type                  mem_ff [sttk_pkg::RspDepth];
   logic [sttk_pkg::RspPtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sttk_pkg::RspPtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sttk_pkg::RspCntW-1:0]       count_ff, count_in;
   logic [sttk_pkg::RspPtrW-1:0]       wr_next;
   logic                               pop;
   sttk_pkg::rsp_type                  head;

   // two free slots guarantee any byte's results fit
   assign room    = count_ff <= sttk_pkg::RspCntW'(sttk_pkg::RspDepth - 2);
   assign wr_next = wr_ptr_ff + sttk_pkg::RspPtrW'(1);
   assign head    = mem_ff[rd_ptr_ff];

   assign rsp_chan.valid        = count_ff != '0;
   assign pop                   = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.has_char     = head.has_char;
   assign rsp_chan.value_char   = head.value_char;
   assign rsp_chan.token_end    = head.token_end;
   assign rsp_chan.token_class  = head.token_class;
   assign rsp_chan.keyword_id   = head.keyword_id;
   assign rsp_chan.value_length = head.value_length;
   assign rsp_chan.truncated    = head.truncated;
   assign rsp_chan.last_of_run  = head.last_of_run;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sttk_pkg::RspPtrW'(push.count);
      rd_ptr_in = rd_ptr_ff + sttk_pkg::RspPtrW'(pop);
      count_in  = count_ff + sttk_pkg::RspCntW'(push.count) - sttk_pkg::RspCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sttk_pkg::RspCntW'(sttk_pkg::RspDepth))
      else $error("result queue overfilled");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("results pushed without two free slots");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff != sttk_pkg::RspCntW'(sttk_pkg::RspDepth)
      |-> sttk_pkg::RspPtrW'(wr_ptr_ff - rd_ptr_ff) == count_ff[sttk_pkg::RspPtrW-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

>>> sv/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the streaming source text tokenizer.
// Depends on sttk_pkg, sttk_if, sttk_scan and sttk_rsp_fifo.
//
// Usage:
//   req_chan carries one source byte per transfer (ch); a zero byte ends the
//   text. rsp_chan carries the results: token characters as they arrive, end
//   markers with class, keyword id, length and truncation flag, and an eof
//   marker. last_of_run marks the last result caused by a byte.
//   A byte is captured in an input register, scanned once the queue has room, and
//   its zero, one or two results are written into a four-entry result queue.
//   A byte's first result is registered in the queue when the byte is scanned;
//   with the queue empty it is offered on rsp_chan in the next cycle.
//   Throughput: one byte per cycle while the receiver keeps up and the queue
//   has room; the result port delivers one result per cycle, so a byte that
//   gives two results needs a transfer for each.
//   A byte is scanned only when the queue has two free entries; when the
//   receiver stalls the queue fills, the byte waits in the input register
//   and req_chan.ready drops. No result is lost or repeated.
//   Synchronous reset empties the queue and input register and returns the
//   scanner to idle between tokens; no clearing pass is needed.
module source_text_tokenizer (
   input  logic         clock,
   input  logic         reset,
   sttk_req_if.sink     req_chan,
   sttk_rsp_if.source   rsp_chan
);

   sttk_pkg::push_type  push;
   logic                room;

   sttk_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .room     (room),
      .push     (push)
   );

   sttk_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> test/sttk_token_checker.sv
`timescale 1ns / 1ps
// Scoreboard for source_text_tokenizer: predicts the results of every accepted byte
// and compares them, in order, with the result channel. Depends on sttk_pkg, sttk_if.
module sttk_token_checker (
   input  logic clock,
   input  logic reset,
   sttk_req_if  req_chan,
   sttk_rsp_if  rsp_chan,
   output int   failures,
   output int   results_pending
);

   string      keyword_text [sttk_pkg::KwCount] =
                  '{"fn", "let", "int", "str", "return", "if", "while"};

   logic [2:0] scan_mode  = sttk_pkg::ModeIdle;
   int         kept_chars = 0;
   logic       dropped    = 1'b0;
   logic [7:0] head [6];            // leading characters, enough for the longest keyword
   sttk_pkg::rsp_type expected_q [$];
   int         run_results;

   function automatic logic letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic void push_result(sttk_pkg::rsp_type r);
      expected_q.push_back(r);
      run_results++;
   endfunction

   function automatic sttk_pkg::rsp_type symbol_result(logic [7:0] c);
      sttk_pkg::rsp_type r;
      r              = '0;
      r.has_char     = 1'b1;
      r.value_char   = c;
      r.token_end    = 1'b1;
      r.token_class  = sttk_pkg::ClsSymbol;
      r.value_length = 8'd1;
      return r;
   endfunction

   function automatic void push_eof();
      sttk_pkg::rsp_type r;
      r             = '0;
      r.token_end   = 1'b1;
      r.token_class = sttk_pkg::ClsEof;
      push_result(r);
      scan_mode = sttk_pkg::ModeIdle;
   endfunction

   function automatic void start_token(logic [2:0] mode);
      scan_mode  = mode;
      kept_chars = 0;
      dropped    = 1'b0;
   endfunction

   function automatic void add_char(logic [7:0] c);
      sttk_pkg::rsp_type r;
      if (kept_chars >= sttk_pkg::MaxTokenChars) begin
         dropped = 1'b1;
         return;
      end
      if (kept_chars < 6) head[kept_chars] = c;
      r            = '0;
      r.has_char   = 1'b1;
      r.value_char = c;
      push_result(r);
      kept_chars++;
   endfunction

   function automatic void close_token(logic [2:0] cls);
      sttk_pkg::rsp_type r;
      logic    hit;
      r             = '0;
      r.token_end   = 1'b1;
      r.token_class = cls;
      // a keyword is an untruncated identifier spelled exactly like one
      if (cls == sttk_pkg::ClsIdent && !dropped) begin
         for (int k = 0; k < sttk_pkg::KwCount; k++) begin
            if (keyword_text[k].len() == kept_chars) begin
               hit = 1'b1;
               for (int i = 0; i < kept_chars; i++)
                  if (keyword_text[k][i] != head[i]) hit = 1'b0;
               if (hit) begin
                  r.token_class = sttk_pkg::ClsKeyword;
                  r.keyword_id  = 3'(k + 1);
               end
            end
         end
      end
      r.value_length = (kept_chars > sttk_pkg::LenMax) ? 8'(sttk_pkg::LenMax)
                                                       : 8'(kept_chars);
      r.truncated    = dropped;
      push_result(r);
      scan_mode = sttk_pkg::ModeIdle;
   endfunction

   function automatic void scan_between(logic [7:0] c);
      scan_mode = sttk_pkg::ModeIdle;
      if (c == sttk_pkg::ChEnd) push_eof();
      else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
         // whitespace between tokens gives nothing
      end else if (c == sttk_pkg::ChSlash) scan_mode = sttk_pkg::ModeSlash;
      else if (letter(c) || c == sttk_pkg::ChUnderscore) begin
         start_token(sttk_pkg::ModeIdent);
         add_char(c);
      end else if (digit(c)) begin
         start_token(sttk_pkg::ModeNumber);
         add_char(c);
      end else if (c == sttk_pkg::ChQuote) start_token(sttk_pkg::ModeString);
      else push_result(symbol_result(c));
   endfunction

   function automatic void scan_byte(logic [7:0] c);
      sttk_pkg::rsp_type tail;
      run_results = 0;
      unique case (scan_mode)
         sttk_pkg::ModeSlash: begin
            if (c == sttk_pkg::ChSlash) scan_mode = sttk_pkg::ModeComment;
            else begin
               push_result(symbol_result(sttk_pkg::ChSlash));
               scan_between(c);
            end
         end
         sttk_pkg::ModeComment: begin
            if (c == sttk_pkg::ChEnd) push_eof();
            else if (c == sttk_pkg::ChNewline) scan_mode = sttk_pkg::ModeIdle;
         end
         sttk_pkg::ModeIdent: begin
            if (letter(c) || digit(c) || c == sttk_pkg::ChUnderscore) add_char(c);
            else begin
               close_token(sttk_pkg::ClsIdent);
               scan_between(c);
            end
         end
         sttk_pkg::ModeNumber: begin
            if (digit(c)) add_char(c);
            else begin
               close_token(sttk_pkg::ClsNumber);
               scan_between(c);
            end
         end
         sttk_pkg::ModeString: begin
            if (c == sttk_pkg::ChQuote) close_token(sttk_pkg::ClsString);
            else if (c == sttk_pkg::ChEnd) begin
               close_token(sttk_pkg::ClsString);
               push_eof();
            end else add_char(c);
         end
         default: scan_between(c);
      endcase
      if (run_results > 0) begin
         tail             = expected_q.pop_back();
         tail.last_of_run = 1'b1;
         expected_q.push_back(tail);
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : watch
      sttk_pkg::rsp_type want;
      if (reset) begin
         scan_mode  = sttk_pkg::ModeIdle;
         kept_chars = 0;
         dropped    = 1'b0;
         failures   = 0;
         expected_q.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) scan_byte(req_chan.ch);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected: value_char %0d token_end %0d",
                      rsp_chan.value_char, rsp_chan.token_end);
               failures++;
            end else begin
               want = expected_q.pop_front();
               check_field("has_char", 8'(want.has_char), 8'(rsp_chan.has_char));
               check_field("value_char", want.value_char, rsp_chan.value_char);
               check_field("token_end", 8'(want.token_end), 8'(rsp_chan.token_end));
               check_field("token_class", 8'(want.token_class), 8'(rsp_chan.token_class));
               check_field("keyword_id", 8'(want.keyword_id), 8'(rsp_chan.keyword_id));
               check_field("value_length", want.value_length, rsp_chan.value_length);
               check_field("truncated", 8'(want.truncated), 8'(rsp_chan.truncated));
               check_field("last_of_run", 8'(want.last_of_run), 8'(rsp_chan.last_of_run));
            end
         end
      end
      results_pending = expected_q.size();
   end

endmodule

>>> test/tb_source_text_tokenizer.sv
`timescale 1ns / 1ps
// Testbench top for source_text_tokenizer: clock, reset, byte stimulus and receiver stalls.
// Depends on sttk_pkg, sttk_if, the block itself and sttk_token_checker.
module tb_source_text_tokenizer;

   localparam int StimulusBytes  = 1800;
   localparam int StallLimit     = 3000;
   localparam int HoldCycles     = 250;
   localparam int HoldAfterBytes = 700;
   localparam int DrainCycles    = 20;

   typedef enum {DrainSteady, DrainPatchy, DrainSparse} drain_mode_type;

   logic  clock = 1'b0;
   logic  reset;
   int    failures;
   int    results_pending;
   int    bytes_sent  = 0;
   int    burst_left  = 0;
   int    idle_cycles = 0;
   string keyword_text [sttk_pkg::KwCount] =
             '{"fn", "let", "int", "str", "return", "if", "while"};
   string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string punct_chars = "!#$%&'()*+,-.:;<=>?@[\\]^{|}~";

   sttk_req_if req_chan ();
   sttk_rsp_if rsp_chan ();

   source_text_tokenizer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sttk_token_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .failures        (failures),
      .results_pending (results_pending)
   );

   always #5 clock = ~clock;

   // ends the run when neither channel has had a transfer for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (idle_cycles == StallLimit) begin
         $display("FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic logic [7:0] ident_char(bit leading);
      return 8'(ident_chars[$urandom_range(0, leading ? 52 : 62)]);
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_chan.valid <= 1'b1;
      req_chan.ch    <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_word(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   initial begin : drain
      drain_mode_type mode;
      int          span;
      int          hold_left;
      bit          hold_done;
      mode      = DrainSteady;
      span      = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         // one long hold-off so the result queue fills and the input backs up
         if (!hold_done && bytes_sent >= HoldAfterBytes) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            if (span == 0) begin
               mode = drain_mode_type'($urandom_range(0, 2));
               span = $urandom_range(8, 60);
            end
            span--;
            unique case (mode)
               DrainSteady: rsp_chan.ready <= 1'b1;
               DrainPatchy: rsp_chan.ready <= 1'($urandom_range(0, 1));
               default:     rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int         token_index;
      int         pick;
      int         span;
      int         k;
      logic [7:0] c;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.ch    = 8'h00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // keyword ended by a blank, identifier ended by a symbol, number ended by a lone slash
      send_word("if _Z9(09/x");
      // comment holding a high byte, then a quoted string
      send_word("//c");
      send_byte(8'hFF);
      send_byte(sttk_pkg::ChNewline);
      send_word("\"a\"");
      // high bytes between tokens are symbols
      send_byte(8'hFF);
      send_byte(8'h80);
      // open string, held slash and comment, each ended by end of text, then a bare end
      send_word("\"q");
      send_byte(sttk_pkg::ChEnd);
      send_byte(sttk_pkg::ChSlash);
      send_byte(sttk_pkg::ChEnd);
      send_word("//");
      send_byte(sttk_pkg::ChEnd);
      send_byte(sttk_pkg::ChEnd);

      token_index = 0;
      while (bytes_sent < StimulusBytes) begin
         token_index++;
         if (token_index == 10 || token_index == 90 || token_index == 170) begin
            // tokens at the length limit, one past it, and well past it
            span = (token_index == 10) ? sttk_pkg::MaxTokenChars :
                   (token_index == 90) ? sttk_pkg::MaxTokenChars + 1 :
                   $urandom_range(sttk_pkg::MaxTokenChars + 2, sttk_pkg::MaxTokenChars + 45);
            if (token_index == 170) send_byte(sttk_pkg::ChQuote);
            for (int i = 0; i < span; i++) begin
               if (token_index == 90) c = 8'($urandom_range(8'h30, 8'h39));
               else c = ident_char(i == 0);
               send_byte(c);
            end
            if (token_index == 170) send_byte(sttk_pkg::ChQuote);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 14) send_word(keyword_text[$urandom_range(0, sttk_pkg::KwCount - 1)]);
            else if (pick < 20) begin
               // near misses: a keyword cut short or extended by one character
               k = $urandom_range(0, sttk_pkg::KwCount - 1);
               if ($urandom_range(0, 1) == 0)
                  for (int i = 0; i < keyword_text[k].len() - 1; i++)
                     send_byte(keyword_text[k][i]);
               else begin
                  send_word(keyword_text[k]);
                  send_byte(ident_char(1'b0));
               end
            end else if (pick < 34) begin
               span = $urandom_range(1, 10);
               for (int i = 0; i < span; i++) send_byte(ident_char(i == 0));
            end else if (pick < 44) begin
               repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(8'h30, 8'h39)));
            end else if (pick < 60) begin
               // strings, a part of them left open until end of text
               send_byte(sttk_pkg::ChQuote);
               repeat ($urandom_range(0, 10)) begin
                  do c = 8'($urandom_range(1, 255));
                  while (c == sttk_pkg::ChQuote);
                  send_byte(c);
               end
               send_byte(pick < 53 ? sttk_pkg::ChQuote : sttk_pkg::ChEnd);
            end else if (pick < 70) begin
               k = $urandom_range(0, 2);
               if (k == 0) c = 8'($urandom_range(128, 255));
               else if (k == 1) c = 8'($urandom_range(14, 31));
               else c = 8'(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
               send_byte(c);
            end else if (pick < 76) begin
               send_word("//");
               repeat ($urandom_range(0, 12)) begin
                  do c = 8'($urandom_range(1, 255));
                  while (c == sttk_pkg::ChNewline);
                  send_byte(c);
               end
               send_byte(sttk_pkg::ChNewline);
            end else if (pick < 81) send_byte(sttk_pkg::ChSlash);
            else if (pick < 85) send_byte(sttk_pkg::ChEnd);
            else begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
         end
         repeat ($urandom_range(0, 2)) begin
            k = $urandom_range(0, 5);
            send_byte(k == 5 ? 8'h20 : 8'(9 + k));
         end
      end
      send_byte(sttk_pkg::ChEnd);
      req_chan.valid <= 1'b0;

      while (results_pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
sv/sttk_pkg.sv
sv/sttk_if.sv
sv/sttk_scan.sv
sv/sttk_rsp_fifo.sv
sv/source_text_tokenizer.sv
test/sttk_token_checker.sv
test/tb_source_text_tokenizer.sv
